@@ hdl/efr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and codes for the escaped frame receiver with XOR check.
// ----------------------------------------------------------------------------
package efr_pkg;

   // field widths fixed by the interface
   localparam int ByteW   = 8;
   localparam int IndexW  = 6;
   localparam int StatusW = 3;
   localparam int LengthW = 7;
   localparam int CsrIdxW = 2;

   // register indexes on the csr port
   localparam logic [CsrIdxW-1:0] CSR_START_BYTE  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_STOP_BYTE   = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_ESCAPE_BYTE = 2'd2;

   // register reset values
   localparam logic [ByteW-1:0] START_BYTE_RESET  = 8'd125;
   localparam logic [ByteW-1:0] STOP_BYTE_RESET   = 8'd126;
   localparam logic [ByteW-1:0] ESCAPE_BYTE_RESET = 8'd127;

   // frame status codes
   localparam logic [StatusW-1:0] STATUS_NONE      = 3'd0;
   localparam logic [StatusW-1:0] STATUS_GOOD      = 3'd1;
   localparam logic [StatusW-1:0] STATUS_CHECK_ERR = 3'd2;
   localparam logic [StatusW-1:0] STATUS_ABORTED   = 3'd3;
   localparam logic [StatusW-1:0] STATUS_RESTARTED = 3'd4;

   // receive mode, one-hot
   typedef enum logic [3:0] {
      MODE_HUNT      = 4'b0001,
      MODE_SKIP      = 4'b0010,
      MODE_FRAME     = 4'b0100,
      MODE_FRAME_ESC = 4'b1000
   } rx_mode_type;

   // framing bytes from the csr registers
   typedef struct packed {
      logic [ByteW-1:0] start_byte;
      logic [ByteW-1:0] stop_byte;
      logic [ByteW-1:0] escape_byte;
   } efr_cfg_type;

   // one result item
   typedef struct packed {
      logic               byte_valid;
      logic [ByteW-1:0]   data_byte;
      logic [IndexW-1:0]  byte_index;
      logic [StatusW-1:0] frame_status;
      logic [LengthW-1:0] frame_length;
   } efr_rsp_type;

endpackage

@@ hdl/escaped_frame_receiver_xor_check_core.sv @@
`timescale 1ns / 1ps
// rsp_valid rises once a request has passed the input register and then the
// result register, which holds it back while full and not being drained;
// one request per cycle sustained, set by the frame state update, while the
// result register can take a result; requests that give no result wait too.
// Reset (synchronous, active high) returns to hunting with count and XOR at
// zero, empties both registers and restores the framing bytes to 125/126/127.
// ----------------------------------------------------------------------------
// escaped_frame_receiver_xor_check_core
// Escaped-byte frame decoder with XOR checksum: emits each stored byte with
// its index and a frame status at frame end or restart.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_xor_check_core #(
   parameter int BUFFER_LENGTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_byte_valid,
   output logic [7:0] rsp_data_byte,
   output logic [5:0] rsp_byte_index,
   output logic [2:0] rsp_frame_status,
   output logic [6:0] rsp_frame_length,
   // register write port
   input  logic       csr_wen,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import efr_pkg::*;

   efr_cfg_type      cfg_ff;
   logic             in_valid_ff;
   logic [ByteW-1:0] in_byte_ff;
   logic             can_load, step, has_result;
   efr_rsp_type      result, rsp_data;

   // framing byte registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte  <= START_BYTE_RESET;
         cfg_ff.stop_byte   <= STOP_BYTE_RESET;
         cfg_ff.escape_byte <= ESCAPE_BYTE_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_START_BYTE:  cfg_ff.start_byte  <= csr_wdata;
            CSR_STOP_BYTE:   cfg_ff.stop_byte   <= csr_wdata;
            CSR_ESCAPE_BYTE: cfg_ff.escape_byte <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register advances whenever the result register can take a result
   assign step      = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   efr_frame_engine #(
      .BUFFER_LENGTH (BUFFER_LENGTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .cfg        (cfg_ff),
      .has_result (has_result),
      .result     (result)
   );

   efr_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step && has_result),
      .load_data (result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_byte_valid   = rsp_data.byte_valid;
   assign rsp_data_byte    = rsp_data.data_byte;
   assign rsp_byte_index   = rsp_data.byte_index;
   assign rsp_frame_status = rsp_data.frame_status;
   assign rsp_frame_length = rsp_data.frame_length;

endmodule

@@ hdl/efr_frame_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_frame_engine
// Frame state machine: unescapes bytes, tracks count and running XOR, and
// forms the result for one byte combinationally.
// ----------------------------------------------------------------------------
module efr_frame_engine #(
   parameter int BUFFER_LENGTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 rx_byte,
   input  efr_pkg::efr_cfg_type       cfg,
   output logic                       has_result,
   output efr_pkg::efr_rsp_type       result
);
   import efr_pkg::*;

   localparam int CntW = $clog2(BUFFER_LENGTH + 1);
   localparam logic [CntW-1:0] CntFull = CntW'(BUFFER_LENGTH);

   rx_mode_type        mode_ff, mode_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [ByteW-1:0]   xor_ff, xor_in;
   logic [ByteW-1:0]   last_ff, last_in;
   logic [ByteW-1:0]   second_ff, second_in;

   logic               is_esc, is_start, is_stop, full;
   logic [CntW-1:0]    count_st;
   logic [ByteW-1:0]   xor_st;
   logic [CntW+6:0]    count_ext, count_st_ext;
   logic [StatusW-1:0] check_now, check_st;

   // byte classification and the values after storing this byte
   always_comb begin
      is_esc       = (rx_byte == cfg.escape_byte);
      is_start     = (rx_byte == cfg.start_byte);
      is_stop      = (rx_byte == cfg.stop_byte);
      full         = (count_ff >= CntFull);
      count_st     = count_ff + 1'b1;
      xor_st       = xor_ff ^ second_ff;
      count_ext    = {7'd0, count_ff};
      count_st_ext = {7'd0, count_st};
      check_now    = (xor_ff == second_ff) ? STATUS_GOOD : STATUS_CHECK_ERR;
      check_st     = (xor_st == last_ff) ? STATUS_GOOD : STATUS_CHECK_ERR;
   end

   // next state and result
   always_comb begin
      mode_in    = mode_ff;
      count_in   = count_ff;
      xor_in     = xor_ff;
      last_in    = last_ff;
      second_in  = second_ff;
      has_result = 1'b0;
      result     = '0;
      case (mode_ff)
         MODE_HUNT: begin
            if (is_esc) begin
               mode_in = MODE_SKIP;
            end else if (is_start) begin
               mode_in           = MODE_FRAME;
               count_in          = CntW'(1);
               xor_in            = '0;
               second_in         = '0;
               last_in           = cfg.start_byte;
               has_result        = 1'b1;
               result.byte_valid = 1'b1;
               result.data_byte  = rx_byte;
            end
         end
         MODE_SKIP: begin
            mode_in = MODE_HUNT;
         end
         MODE_FRAME: begin
            if (is_esc) begin
               mode_in = MODE_FRAME_ESC;
            end else if (is_start) begin
               count_in            = CntW'(1);
               xor_in              = '0;
               second_in           = '0;
               last_in             = cfg.start_byte;
               has_result          = 1'b1;
               result.byte_valid   = 1'b1;
               result.data_byte    = rx_byte;
               result.frame_status = STATUS_RESTARTED;
            end else if (full) begin
               // buffer full: drop the byte and close the frame
               mode_in             = MODE_HUNT;
               has_result          = 1'b1;
               result.frame_status = check_now;
               result.frame_length = count_ext[LengthW-1:0];
            end else begin
               count_in          = count_st;
               xor_in            = xor_st;
               second_in         = last_ff;
               last_in           = rx_byte;
               has_result        = 1'b1;
               result.byte_valid = 1'b1;
               result.data_byte  = rx_byte;
               result.byte_index = count_ext[IndexW-1:0];
               if (is_stop) begin
                  mode_in             = MODE_HUNT;
                  result.frame_status = check_st;
                  result.frame_length = count_st_ext[LengthW-1:0];
               end
            end
         end
         MODE_FRAME_ESC: begin
            has_result = 1'b1;
            if (full) begin
               // escaped byte with no room left aborts the frame
               mode_in             = MODE_HUNT;
               result.frame_status = STATUS_ABORTED;
            end else begin
               mode_in           = MODE_FRAME;
               count_in          = count_st;
               xor_in            = xor_st;
               second_in         = last_ff;
               last_in           = rx_byte;
               result.byte_valid = 1'b1;
               result.data_byte  = rx_byte;
               result.byte_index = count_ext[IndexW-1:0];
            end
         end
         default: begin
            mode_in = MODE_HUNT;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_HUNT;
         count_ff  <= '0;
         xor_ff    <= '0;
         last_ff   <= '0;
         second_ff <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         xor_ff    <= xor_in;
         last_ff   <= last_in;
         second_ff <= second_in;
      end
   end

endmodule

@@ hdl/efr_rsp_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_rsp_reg
// Result register: holds one response until the downstream side takes it.
// ----------------------------------------------------------------------------
module efr_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  efr_pkg::efr_rsp_type load_data,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output efr_pkg::efr_rsp_type rsp_data
);
   import efr_pkg::*;

   logic        valid_ff, valid_in;
   efr_rsp_type data_ff;

   // register is free when empty or being drained this cycle
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the escaped-byte frame decoder with XOR checksum.
// A driver feeds link bytes and register writes from a queue; a cycle-level
// predictor tracks the framing state and the checksum and expects each stored
// byte and frame status in order. Directed bytes cover the framing cases, then
// random frames run under several framing-byte settings, including overlaps.
// ----------------------------------------------------------------------------
module tb;
   import efr_pkg::*;

   localparam int BUFFER_LENGTH = 64;
   localparam int DRAIN_CYCLES  = 4;
   localparam int CYCLE_LIMIT   = 600000;

   // one entry of the link stream: a byte or a register write
   typedef struct {
      bit         is_csr;
      logic [1:0] csr_idx;
      logic [7:0] value;
   } stream_op_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_byte_valid;
   logic [7:0] rsp_data_byte;
   logic [5:0] rsp_byte_index;
   logic [2:0] rsp_frame_status;
   logic [6:0] rsp_frame_length;
   logic       csr_wen = 1'b0;
   logic [1:0] csr_index = 2'd0;
   logic [7:0] csr_wdata = 8'd0;

   stream_op_type rx_stream[$];
   efr_rsp_type   frame_results_due[$];

   // predictor state and framing bytes
   efr_cfg_type frame_cfg;
   rx_mode_type rx_state;
   logic [6:0]  held_count;
   logic [7:0]  xor_acc;
   logic [7:0]  newest_byte;
   logic [7:0]  prior_byte;

   // framing bytes as seen by the stream builder
   logic [7:0] gen_start = START_BYTE_RESET;
   logic [7:0] gen_stop  = STOP_BYTE_RESET;
   logic [7:0] gen_esc   = ESCAPE_BYTE_RESET;
   int         stream_bytes = 0;

   bit req_fire = 1'b0;
   int quiet_cycles = 0;
   int req_gap_left = 0;
   int req_calm_left = 0;
   int rsp_stall_left = 0;
   int rsp_calm_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   escaped_frame_receiver_xor_check_core #(
      .BUFFER_LENGTH(BUFFER_LENGTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_frame_status(rsp_frame_status),
      .rsp_frame_length(rsp_frame_length),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   function automatic void open_frame();
      xor_acc     = 8'd0;
      prior_byte  = 8'd0;
      newest_byte = frame_cfg.start_byte;
      held_count  = 7'd1;
   endfunction

   function automatic void store_byte(input logic [7:0] b);
      xor_acc     = xor_acc ^ prior_byte;
      prior_byte  = newest_byte;
      newest_byte = b;
      held_count  = held_count + 7'd1;
   endfunction

   function automatic logic [2:0] checksum_status();
      return (xor_acc == prior_byte) ? STATUS_GOOD : STATUS_CHECK_ERR;
   endfunction

   // advance the framing state by one link byte; returns 1 when a result is due
   function automatic bit decode_byte(input logic [7:0] b, output efr_rsp_type res);
      logic [5:0] slot;
      res = '0;
      case (rx_state)
         MODE_HUNT: begin
            // escape wins over start
            if (b == frame_cfg.escape_byte) begin
               rx_state = MODE_SKIP;
               return 1'b0;
            end
            if (b == frame_cfg.start_byte) begin
               open_frame();
               rx_state = MODE_FRAME;
               res.byte_valid = 1'b1;
               res.data_byte  = b;
               return 1'b1;
            end
            return 1'b0;
         end
         MODE_SKIP: begin
            rx_state = MODE_HUNT;
            return 1'b0;
         end
         MODE_FRAME: begin
            if (b == frame_cfg.escape_byte) begin
               rx_state = MODE_FRAME_ESC;
               return 1'b0;
            end
            // restart: start byte stored again at index 0
            if (b == frame_cfg.start_byte) begin
               open_frame();
               res.byte_valid   = 1'b1;
               res.data_byte    = b;
               res.frame_status = STATUS_RESTARTED;
               return 1'b1;
            end
            // buffer full: ordinary byte dropped, frame ends
            if (held_count >= BUFFER_LENGTH) begin
               rx_state = MODE_HUNT;
               res.frame_status = checksum_status();
               res.frame_length = held_count;
               return 1'b1;
            end
            slot = held_count[5:0];
            store_byte(b);
            res.byte_valid = 1'b1;
            res.data_byte  = b;
            res.byte_index = slot;
            if (b == frame_cfg.stop_byte) begin
               rx_state = MODE_HUNT;
               res.frame_status = checksum_status();
               res.frame_length = held_count;
            end
            return 1'b1;
         end
         default: begin
            // byte after escape inside a frame; aborts on a full buffer
            if (held_count >= BUFFER_LENGTH) begin
               rx_state = MODE_HUNT;
               res.frame_status = STATUS_ABORTED;
               return 1'b1;
            end
            slot = held_count[5:0];
            store_byte(b);
            rx_state = MODE_FRAME;
            res.byte_valid = 1'b1;
            res.data_byte  = b;
            res.byte_index = slot;
            return 1'b1;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // stream builder
   // ------------------------------------------------------------------------

   task automatic push_byte(input logic [7:0] b);
      stream_op_type op;
      op.is_csr  = 1'b0;
      op.csr_idx = '0;
      op.value   = b;
      rx_stream.push_back(op);
      stream_bytes++;
   endtask

   task automatic push_csr(input logic [1:0] idx, input logic [7:0] v);
      stream_op_type op;
      op.is_csr  = 1'b1;
      op.csr_idx = idx;
      op.value   = v;
      rx_stream.push_back(op);
      case (idx)
         CSR_START_BYTE: gen_start = v;
         CSR_STOP_BYTE:  gen_stop  = v;
         default:        gen_esc   = v;
      endcase
   endtask

   // frame content byte, escaped when it collides with a framing byte
   task automatic push_stored(input logic [7:0] b);
      if (b == gen_start || b == gen_stop || b == gen_esc)
         push_byte(gen_esc);
      push_byte(b);
   endtask

   function automatic logic [7:0] random_payload();
      case ($urandom_range(0, 11))
         0:       return gen_start;
         1:       return gen_stop;
         2:       return gen_esc;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int payload_len();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(13, BUFFER_LENGTH - 3);
      return $urandom_range(0, 12);
   endfunction

   // start, payload, checksum, stop
   task automatic queue_frame(input int n_payload, input bit good_sum);
      logic [7:0] sum;
      logic [7:0] b;
      push_byte(gen_start);
      sum = gen_start;
      for (int i = 0; i < n_payload; i++) begin
         b = random_payload();
         sum = sum ^ b;
         push_stored(b);
      end
      if (!good_sum)
         sum = sum ^ 8'($urandom_range(1, 255));
      push_stored(sum);
      push_byte(gen_stop);
   endtask

   // fill the buffer, then one more byte plain or escaped
   task automatic queue_overflow(input bit by_escape);
      logic [7:0] sum;
      logic [7:0] b;
      bit         good;
      good = $urandom_range(0, 1);
      push_byte(gen_start);
      sum = gen_start;
      for (int i = 0; i < BUFFER_LENGTH - 1; i++) begin
         b = (good && i == BUFFER_LENGTH - 3) ? sum : random_payload();
         sum = sum ^ b;
         push_stored(b);
      end
      if (by_escape) begin
         push_byte(gen_esc);
         push_byte(8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 1)) begin
         push_byte(gen_stop);
      end else begin
         do
            b = 8'($urandom_range(0, 255));
         while (b == gen_start || b == gen_esc);
         push_byte(b);
      end
   endtask

   task automatic run_phase(input logic [7:0] s, input logic [7:0] p,
                            input logic [7:0] e, input int budget);
      int first;
      int pick;
      push_csr(CSR_START_BYTE, s);
      push_csr(CSR_STOP_BYTE, p);
      push_csr(CSR_ESCAPE_BYTE, e);
      first = stream_bytes;
      if (budget > 100) begin
         queue_overflow(1'b0);
         queue_overflow(1'b1);
      end
      while (stream_bytes - first < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            queue_frame(payload_len(), 1'b1);
         end else if (pick < 65) begin
            queue_frame(payload_len(), 1'b0);
         end else if (pick < 77) begin
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
         end else if (pick < 89) begin
            // partial frame cut short by a new start
            push_byte(gen_start);
            repeat ($urandom_range(0, 5)) push_stored(random_payload());
            queue_frame(payload_len(), $urandom_range(0, 1));
         end else if (pick < 92) begin
            queue_overflow(1'b0);
         end else if (pick < 95) begin
            queue_overflow(1'b1);
         end else begin
            // escaped start while hunting is skipped
            push_byte(gen_esc);
            push_byte(gen_start);
         end
      end
   endtask

   // mostly short gaps, a few long ones, and calm stretches with none
   function automatic int idle_length(inout int calm_left);
      int pick;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2)
         calm_left = $urandom_range(20, 80);
      if (pick < 60)
         return 0;
      if (pick < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      stream_op_type op;
      logic          next_valid;
      logic [7:0]    next_byte;
      logic          next_wen;
      logic [1:0]    next_idx;
      logic [7:0]    next_wdata;
      next_valid = req_valid;
      next_byte  = req_rx_byte;
      next_wen   = 1'b0;
      next_idx   = csr_index;
      next_wdata = csr_wdata;
      if (!reset && !(req_valid && !req_fire)) begin
         next_valid = 1'b0;
         if (req_gap_left > 0) begin
            req_gap_left--;
         end else if (rx_stream.size() != 0) begin
            op = rx_stream[0];
            if (!op.is_csr) begin
               next_valid = 1'b1;
               next_byte  = op.value;
               void'(rx_stream.pop_front());
               req_gap_left = idle_length(req_calm_left);
            end else if (frame_results_due.size() == 0 && quiet_cycles >= DRAIN_CYCLES) begin
               // register writes only once the pipeline has drained
               next_wen   = 1'b1;
               next_idx   = op.csr_idx;
               next_wdata = op.value;
               void'(rx_stream.pop_front());
            end
         end
      end
      req_valid   <= next_valid;
      req_rx_byte <= next_byte;
      csr_wen     <= next_wen;
      csr_index   <= next_idx;
      csr_wdata   <= next_wdata;
   end

   // response back-pressure
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall_left = idle_length(rsp_calm_left);
      end
   end

   // ------------------------------------------------------------------------
   // monitor and checker
   // ------------------------------------------------------------------------

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v)
         note_mismatch($sformatf("%s expected %0d got %0d", name, want_v, got_v));
   endtask

   always @(posedge clock) begin
      efr_rsp_type got;
      efr_rsp_type want;
      efr_rsp_type predicted;
      if (reset) begin
         req_fire     <= 1'b0;
         quiet_cycles <= 0;
         frame_cfg.start_byte  = START_BYTE_RESET;
         frame_cfg.stop_byte   = STOP_BYTE_RESET;
         frame_cfg.escape_byte = ESCAPE_BYTE_RESET;
         rx_state    = MODE_HUNT;
         held_count  = 7'd0;
         xor_acc     = 8'd0;
         newest_byte = 8'd0;
         prior_byte  = 8'd0;
      end else begin
         req_fire     <= req_valid && req_ready;
         quiet_cycles <= (req_valid && req_ready) ? 0 : quiet_cycles + 1;

         // register write
         if (csr_wen) begin
            case (csr_index)
               CSR_START_BYTE:  frame_cfg.start_byte  = csr_wdata;
               CSR_STOP_BYTE:   frame_cfg.stop_byte   = csr_wdata;
               CSR_ESCAPE_BYTE: frame_cfg.escape_byte = csr_wdata;
               default: ;
            endcase
         end

         // compare an accepted result with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            got.byte_valid   = rsp_byte_valid;
            got.data_byte    = rsp_data_byte;
            got.byte_index   = rsp_byte_index;
            got.frame_status = rsp_frame_status;
            got.frame_length = rsp_frame_length;
            if (frame_results_due.size() == 0) begin
               note_mismatch($sformatf(
                  "result with none pending: valid %0d data %0d index %0d %s",
                  got.byte_valid, got.data_byte, got.byte_index,
                  $sformatf("status %0d length %0d", got.frame_status,
                            got.frame_length)));
            end else begin
               want = frame_results_due.pop_front();
               check_field("byte_valid", want.byte_valid, got.byte_valid);
               check_field("data_byte", want.data_byte, got.data_byte);
               check_field("byte_index", want.byte_index, got.byte_index);
               check_field("frame_status", want.frame_status, got.frame_status);
               check_field("frame_length", want.frame_length, got.frame_length);
            end
         end

         // predict from an accepted request
         if (req_valid && req_ready) begin
            if (decode_byte(req_rx_byte, predicted))
               frame_results_due.push_back(predicted);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL escaped_frame_receiver_xor_check_core");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      logic [7:0] s;
      logic [7:0] p;
      logic [7:0] e;

      // directed bytes at the reset framing values
      push_byte(8'h00);                  // ignored while hunting
      push_byte(8'hFF);
      push_byte(ESCAPE_BYTE_RESET);      // escape while hunting skips the start
      push_byte(START_BYTE_RESET);
      push_byte(START_BYTE_RESET);       // frame opens at index 0
      push_byte(8'h00);
      push_byte(ESCAPE_BYTE_RESET);      // escaped stop stored as data
      push_byte(STOP_BYTE_RESET);
      push_byte(ESCAPE_BYTE_RESET);      // escaped start stored as data
      push_byte(START_BYTE_RESET);
      push_byte(8'hFF);
      push_byte(START_BYTE_RESET);       // restart inside a frame
      push_byte(8'h12);
      push_byte(START_BYTE_RESET ^ 8'h12);
      push_byte(STOP_BYTE_RESET);        // good checksum
      push_byte(START_BYTE_RESET);
      push_byte(8'h01);
      push_byte(8'h00);
      push_byte(STOP_BYTE_RESET);        // checksum error
      push_byte(START_BYTE_RESET);
      push_byte(STOP_BYTE_RESET);        // shortest frame

      // random phases across framing settings
      run_phase(START_BYTE_RESET, STOP_BYTE_RESET, ESCAPE_BYTE_RESET, 200);
      run_phase(8'h00, 8'hFF, 8'h80, 150);
      run_phase(8'hFF, 8'h00, 8'h01, 150);
      s = 8'($urandom_range(0, 255));
      do p = 8'($urandom_range(0, 255)); while (p == s);
      do e = 8'($urandom_range(0, 255)); while (e == s || e == p);
      run_phase(s, p, e, 150);
      run_phase(8'h55, 8'h55, 8'hAA, 70);   // start wins over stop
      run_phase(8'h33, 8'h44, 8'h33, 70);   // escape wins over start
      run_phase(8'h10, 8'h20, 8'h20, 70);   // escape wins over stop
      run_phase(8'h01, 8'hFE, 8'h00, 130);
      run_phase(START_BYTE_RESET, STOP_BYTE_RESET, ESCAPE_BYTE_RESET, 40);

      // reset
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain
      while (rx_stream.size() != 0 || req_valid)
         @(posedge clock);
      while (frame_results_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && frame_results_due.size() == 0)
         $display("PASS escaped_frame_receiver_xor_check_core");
      else
         $display("FAIL escaped_frame_receiver_xor_check_core");
      $finish;
   end

endmodule
